// ===== hdl/gaussian_sum_potential_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef GAUSSIAN_SUM_POTENTIAL_DEFINES_SVH
`define GAUSSIAN_SUM_POTENTIAL_DEFINES_SVH

// Same-cycle implication, switched off while reset is held
`define GSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gsp_pkg.sv =====
package gsp_pkg;

  // Defaults for the top-level parameters
  localparam int GSP_PEAKS_DEF     = 4;
  localparam int GSP_EXP_DEPTH_DEF = 1024;

  // Field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int ACT_W       = 3;
  localparam int PEAK_REG_W  = 48;
  localparam int ENERGY_W    = 27;
  localparam int OUT_TDATA_W = 32;

  // Register indices
  localparam int CFG_ACTIVE_PEAKS = 0;
  localparam int CFG_PEAK_BASE    = 1;

  // Exponent argument: Q4.6, anything from 16.0 up reads as zero
  localparam int X_LIMIT = 1024;
  localparam int Q_W     = 10;
  localparam int X_SHIFT = 5;

  // Datapath widths
  localparam int DIFF_W = 17;
  localparam int DSQ_W  = 32;
  localparam int NUM_W  = DSQ_W + X_SHIFT;
  localparam int DEN_W  = 32;
  localparam int CMP_W  = DEN_W + Q_W;
  localparam int EXP_W  = 17;
  localparam int TERM_W = 32;

  // Output rounding and clipping
  localparam int RND_BITS   = 8;
  localparam int ROUND_BIAS = 128;
  localparam int ENERGY_MAX = 67108863;
  localparam int ENERGY_MIN = -67108864;

  // exp(-1/64) in Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

  // One peak register: amplitude, mean, sigma (Q8.8 each)
  typedef struct packed {
    logic signed [15:0] amp;
    logic signed [15:0] mean;
    logic [15:0]        sigma;
  } gsp_peak_t;

  // Sample handed from cell to cell
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } gsp_smp_t;

  // Divider stage contents
  typedef struct packed {
    logic             valid;
    logic             over;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } gsp_div_t;

  typedef logic [EXP_W-1:0] exp_tab_t [X_LIMIT];

  // exp(-i/64) in Q1.16, built by repeated rounded multiplication in Q0.32
  function automatic exp_tab_t gsp_exp_table();
    exp_tab_t    tab;
    logic [95:0] t;
    t = 96'd1 << 32;
    for (int i = 0; i < X_LIMIT; i++) begin
      tab[i] = EXP_W'((t + 96'd32768) >> 16);
      t = (t * {32'd0, EXP_STEP_Q32} + (96'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

endpackage

// ===== hdl/gsp_div_stage.sv =====
module gsp_div_stage import gsp_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  gsp_div_t div_i,
  output gsp_div_t div_o
);

  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] den_sh;
  logic             take;
  gsp_div_t         div_nxt;
  gsp_div_t         div_r;

  // Trial subtract of the shifted divisor for one quotient bit
  assign rem_ext = CMP_W'(div_i.rem);
  assign den_sh  = CMP_W'(div_i.den) << SHIFT;
  assign take    = (rem_ext >= den_sh);

  always_comb begin
    div_nxt = div_i;
    if (take) begin
      div_nxt.rem      = NUM_W'(rem_ext - den_sh);
      div_nxt.q[SHIFT] = 1'b1;
    end
  end

  // Advance one stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else if (adv) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

// ===== hdl/gsp_cell.sv =====
module gsp_cell import gsp_pkg::*; #(
  parameter int SUM_W           = TERM_W + 2,
  parameter int EXP_TABLE_DEPTH = GSP_EXP_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    en,
  input  gsp_peak_t               peak,
  input  gsp_smp_t                smp_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output gsp_smp_t                smp_o,
  output logic                    sum_vld_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int ROM_DEPTH = (EXP_TABLE_DEPTH < X_LIMIT) ? EXP_TABLE_DEPTH : X_LIMIT;
  localparam exp_tab_t EXP_TAB = gsp_exp_table();

  gsp_smp_t                 smp_r;
  logic                     v1_r;
  logic signed [DIFF_W-1:0] d_nxt;
  logic signed [DIFF_W-1:0] d_r;
  logic                     v2_r;
  logic signed [2*DIFF_W-1:0] dsq_full;
  logic [DSQ_W-1:0]         dsq_r;
  logic [DEN_W-1:0]         ssq_r;
  logic [NUM_W-1:0]         num;
  gsp_div_t                 div0_r;
  gsp_div_t                 div_w [Q_W+1];
  logic [Q_W-1:0]           x;
  logic                     blank;
  logic                     ve_r;
  logic [EXP_W-1:0]         e_r;
  logic signed [2*DIFF_W-1:0] prod;
  logic                     vt_r;
  logic signed [TERM_W-1:0] term_r;
  logic                     vs_r;
  logic signed [SUM_W-1:0]  sum_r;

  // Hand the sample on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r.valid <= 1'b0;
    end else if (adv) begin
      smp_r <= smp_i;
    end
  end

  assign smp_o = smp_r;

  // Distance to the mean
  assign d_nxt = DIFF_W'(smp_i.sample) - DIFF_W'(peak.mean);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= smp_i.valid;
      d_r  <= d_nxt;
    end
  end

  // Square distance and sigma
  assign dsq_full = d_r * d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r  <= v1_r;
      dsq_r <= dsq_full[DSQ_W-1:0];
      ssq_r <= DEN_W'(peak.sigma) * DEN_W'(peak.sigma);
    end
  end

  // Flag a quotient of 1024 or more; zero sigma lands here too
  assign num = {dsq_r, X_SHIFT'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div0_r.valid <= 1'b0;
    end else if (adv) begin
      div0_r.valid <= v2_r;
      div0_r.over  <= (CMP_W'(num) >= (CMP_W'(ssq_r) << Q_W));
      div0_r.rem   <= num;
      div0_r.den   <= ssq_r;
      div0_r.q     <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage
  assign div_w[0] = div0_r;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    gsp_div_stage #(
      .SHIFT (Q_W - 1 - j)
    ) u_div_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .div_i (div_w[j]),
      .div_o (div_w[j+1])
    );
  end

  // Exponent table read
  assign x     = div_w[Q_W].q;
  assign blank = div_w[Q_W].over || ({1'b0, x} >= (Q_W+1)'(ROM_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= div_w[Q_W].valid;
      if (blank) begin
        e_r <= '0;
      end else begin
        e_r <= EXP_TAB[x];
      end
    end
  end

  // Scale by the amplitude
  assign prod = peak.amp * $signed({1'b0, e_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (adv) begin
      vt_r   <= ve_r;
      term_r <= prod[TERM_W-1:0];
    end
  end

  // Add to the running sum from the previous cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (adv) begin
      vs_r <= vt_r;
      if (en) begin
        sum_r <= sum_i + SUM_W'(term_r);
      end else begin
        sum_r <= sum_i;
      end
    end
  end

  assign sum_vld_o = vs_r;
  assign sum_o     = sum_r;

endmodule

// ===== hdl/gaussian_sum_potential.sv =====
// Channel  Role    Handshake              Payload
// in_      slave   in_tvalid / in_tready  in_tdata[15:0] sample
// out_     master  out_tvalid/out_tready  out_tdata[26:0] energy, out_tuser saturated
// cfg_     write   cfg_we                 cfg_index, cfg_wdata[47:0]
//
// One sample is accepted per clock while the output is not stalled.
// A result passes 15 stages of per-peak term pipeline, dominated by the ten
// one-bit divider stages, then one sum register per cell of the summing
// chain and the output register.
// rst_n is synchronous, active low; it clears the valid flags and the configuration registers.
// While a result waits at the output the whole chain holds and in_tready drops.
module gaussian_sum_potential import gsp_pkg::*; #(
  parameter int PEAKS           = GSP_PEAKS_DEF,
  parameter int EXP_TABLE_DEPTH = GSP_EXP_DEPTH_DEF,
  parameter int CFG_IDX_W       = $clog2(PEAKS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_W-1:0]    in_tdata,   // [15:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [26:0] energy, [31:27] zero
  output logic                   out_tuser,  // [0] saturated
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PEAK_REG_W-1:0]  cfg_wdata
);

  localparam int SUM_W = TERM_W + $clog2(PEAKS);
  localparam int SHR_W = SUM_W + 1 - RND_BITS;
  localparam int RES_W = (SHR_W > ENERGY_W + 1) ? SHR_W : ENERGY_W + 1;
  localparam logic signed [RES_W-1:0] RES_HI = RES_W'(ENERGY_MAX);
  localparam logic signed [RES_W-1:0] RES_LO = RES_W'(ENERGY_MIN);

  logic [ACT_W-1:0]        active_r;
  gsp_peak_t               peak_r [PEAKS];
  logic [PEAKS-1:0]        cell_en;
  logic                    adv;
  gsp_smp_t                smp_w [PEAKS];
  logic signed [SUM_W-1:0] sum_w [PEAKS+1];
  logic                    last_vld;
  logic signed [SUM_W:0]   biased;
  logic signed [SHR_W-1:0] shifted;
  logic signed [RES_W-1:0] wide;
  logic [ENERGY_W-1:0]     energy_nxt;
  logic                    sat_nxt;
  logic                    out_tvalid_r;
  logic [ENERGY_W-1:0]     energy_r;
  logic                    sat_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int k = 0; k < PEAKS; k++) begin
        peak_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_W'(CFG_ACTIVE_PEAKS)) begin
        active_r <= cfg_wdata[ACT_W-1:0];
      end
      for (int k = 0; k < PEAKS; k++) begin
        if (cfg_index == CFG_IDX_W'(CFG_PEAK_BASE + k)) begin
          peak_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // Cells past the active count pass the sum through
  for (genvar k = 0; k < PEAKS; k++) begin : g_en
    assign cell_en[k] = (active_r > ACT_W'(k));
  end

  // The chain advances whenever the output register can take a transaction
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  assign smp_w[0] = {in_tvalid, in_tdata};
  assign sum_w[0] = '0;

  for (genvar k = 0; k < PEAKS; k++) begin : g_cell
    if (k < PEAKS - 1) begin : g_mid
      gsp_cell #(
        .SUM_W           (SUM_W),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .en        (cell_en[k]),
        .peak      (peak_r[k]),
        .smp_i     (smp_w[k]),
        .sum_i     (sum_w[k]),
        .smp_o     (smp_w[k+1]),
        .sum_vld_o (),
        .sum_o     (sum_w[k+1])
      );
    end else begin : g_last
      gsp_cell #(
        .SUM_W           (SUM_W),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .en        (cell_en[k]),
        .peak      (peak_r[k]),
        .smp_i     (smp_w[k]),
        .sum_i     (sum_w[k]),
        .smp_o     (),
        .sum_vld_o (last_vld),
        .sum_o     (sum_w[k+1])
      );
    end
  end

  // Round half up to Q10.16 and clip
  assign biased  = (SUM_W+1)'(sum_w[PEAKS]) + (SUM_W+1)'(ROUND_BIAS);
  assign shifted = biased[SUM_W:RND_BITS];
  assign wide    = RES_W'(shifted);

  always_comb begin
    if (wide > RES_HI) begin
      energy_nxt = RES_HI[ENERGY_W-1:0];
      sat_nxt    = 1'b1;
    end else if (wide < RES_LO) begin
      energy_nxt = RES_LO[ENERGY_W-1:0];
      sat_nxt    = 1'b1;
    end else begin
      energy_nxt = wide[ENERGY_W-1:0];
      sat_nxt    = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= last_vld;
      energy_r     <= energy_nxt;
      sat_r        <= sat_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(energy_r);
  assign out_tuser  = sat_r;

endmodule

// ===== hdl/gsp_checker.sv =====
`include "gaussian_sum_potential_defines.svh"

module gsp_checker import gsp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // Reset empties the output register
  `GSP_ASSERT_NEXT(a_rst_empties, !rst_n, !out_tvalid, "output valid after reset")

  // Input is taken exactly when the output side can move
  `GSP_ASSERT_NOW(a_ready_follows, 1'b1, in_tready == (!out_tvalid || out_tready),
    "in_tready does not follow output backpressure")

  // A clipped result sits at one end of the range
  `GSP_ASSERT_NOW(a_sat_value, out_tvalid && out_tuser,
    out_tdata[ENERGY_W-1:0] == ENERGY_W'(ENERGY_MAX) ||
    out_tdata[ENERGY_W-1:0] == ENERGY_W'(ENERGY_MIN),
    "saturated result not at range limit")

  // A stalled transaction holds
  `GSP_ASSERT_NEXT(a_stall_holds, rst_n && out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind gaussian_sum_potential gsp_checker u_gsp_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gsp_pkg::*;

  localparam int NPEAKS      = GSP_PEAKS_DEF;
  localparam int EXP_DEPTH   = GSP_EXP_DEPTH_DEF;
  localparam int CFG_IDX_W   = $clog2(NPEAKS + 1);
  localparam int LATENCY     = NPEAKS + 15;
  localparam int STALL_LIMIT = 1000;
  localparam int QUIET_LO    = 300;
  localparam int QUIET_HI    = 420;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_DRAIN} stim_op_t;

  typedef struct {
    stim_op_t               op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [PEAK_REG_W-1:0]  val;
  } stim_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic                       sat;
  } energy_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata   = '0;  // [15:0] sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [26:0] energy, [31:27] zero
  logic                   out_tuser;        // [0] saturated
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [PEAK_REG_W-1:0]  cfg_wdata  = '0;

  // Stimulus still to be driven and results still owed by the block
  stim_t   pending [$];
  energy_t energy_q [$];

  // Shadow of the block's registers, updated as the writes go out
  logic [ACT_W-1:0] act_peaks;
  gsp_peak_t        peak_cfg [NPEAKS];

  longint unsigned exp_lut [X_LIMIT];

  int errors       = 0;
  int sent         = 0;
  int got          = 0;
  int stall_cycles = 0;

  gaussian_sum_potential #(
    .PEAKS           (NPEAKS),
    .EXP_TABLE_DEPTH (EXP_DEPTH),
    .CFG_IDX_W       (CFG_IDX_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sum of the active Gaussian peaks at one sample, rounded to Q10.16 and clipped
  function automatic energy_t gauss_energy(logic [SAMPLE_W-1:0] smp);
    longint          acc;
    longint          d;
    longint          scaled;
    longint unsigned dsq;
    longint unsigned ssq;
    longint unsigned x;
    longint unsigned e;
    int              n;
    energy_t         r;
    acc = 0;
    n = (act_peaks > NPEAKS) ? NPEAKS : int'(act_peaks);
    for (int k = 0; k < n; k++) begin
      // zero sigma: the peak adds nothing
      if (peak_cfg[k].sigma != 0) begin
        d   = longint'($signed(smp)) - longint'(peak_cfg[k].mean);
        dsq = longint'(d * d);
        ssq = longint'(peak_cfg[k].sigma) * longint'(peak_cfg[k].sigma);
        x   = (dsq * 32) / ssq;
        // exponent of 16.0 or more reads as zero
        e   = (x < X_LIMIT && x < EXP_DEPTH) ? exp_lut[x] : 0;
        acc += longint'(peak_cfg[k].amp) * longint'(e);
      end
    end
    scaled = (acc + ROUND_BIAS) >>> RND_BITS;
    r.sat = 1'b0;
    if (scaled > ENERGY_MAX) begin
      scaled = ENERGY_MAX;
      r.sat  = 1'b1;
    end else if (scaled < ENERGY_MIN) begin
      scaled = ENERGY_MIN;
      r.sat  = 1'b1;
    end
    r.energy = ENERGY_W'(scaled);
    return r;
  endfunction

  task automatic put_sample(logic [SAMPLE_W-1:0] v);
    pending.push_back('{OP_SAMPLE, '0, PEAK_REG_W'(v)});
  endtask

  task automatic put_cfg(logic [CFG_IDX_W-1:0] idx, logic [PEAK_REG_W-1:0] v);
    pending.push_back('{OP_CFG, idx, v});
  endtask

  task automatic put_drain();
    pending.push_back('{OP_DRAIN, '0, '0});
  endtask

  // New random peaks and active count, then samples mostly around one of the means
  task automatic add_random_phase(int count);
    logic [15:0]           mu [NPEAKS];
    logic [15:0]           sg [NPEAKS];
    logic [15:0]           amp;
    logic [PEAK_REG_W-1:0] w;
    int                    k;
    int                    span;
    int                    off;
    for (k = 0; k < NPEAKS; k++) begin
      amp   = 16'($urandom);
      mu[k] = 16'($urandom);
      case ($urandom_range(0, 9))
        0:       sg[k] = '0;
        1:       sg[k] = 16'hFFFF;
        2:       sg[k] = 16'($urandom_range(1, 15));
        default: sg[k] = 16'($urandom_range(16, 2047));
      endcase
      put_cfg(CFG_IDX_W'(CFG_PEAK_BASE + k), {amp, mu[k], sg[k]});
    end
    // junk above the low three bits must be dropped
    w = {$urandom, $urandom};
    w[ACT_W-1:0] = ($urandom_range(0, 7) == 0) ? 3'd0 : ACT_W'($urandom_range(1, 7));
    put_cfg(CFG_IDX_W'(CFG_ACTIVE_PEAKS), w);
    if ($urandom_range(0, 2) == 0)
      put_cfg(CFG_IDX_W'($urandom_range(NPEAKS + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        put_drain();
      if ($urandom_range(0, 9) < 7) begin
        k    = $urandom_range(0, NPEAKS - 1);
        span = int'(sg[k]) * 12;
        off  = int'($urandom_range(0, span)) - span / 2;
        put_sample(16'(int'($signed(mu[k])) + off));
      end else begin
        put_sample(16'($urandom));
      end
    end
  endtask

  // Driver: hold a sample until it is taken, write registers only when idle
  always @(posedge clk) begin : drive
    logic                  fire;
    logic                  quiet;
    logic                  nxt_valid;
    logic [SAMPLE_W-1:0]   nxt_data;
    logic                  nxt_we;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [PEAK_REG_W-1:0] nxt_wdata;
    stim_t                 head;
    fire      = in_tvalid && in_tready;
    nxt_valid = in_tvalid && !fire;
    nxt_data  = in_tdata;
    nxt_we    = 1'b0;
    nxt_idx   = cfg_index;
    nxt_wdata = cfg_wdata;
    if (fire) begin
      energy_q.push_back(gauss_energy(in_tdata));
      sent++;
    end
    quiet = sent >= QUIET_LO && sent < QUIET_HI;
    if (rst_n && !nxt_valid && pending.size() != 0) begin
      head = pending[0];
      case (head.op)
        OP_SAMPLE: begin
          if (quiet || $urandom_range(0, 99) >= 30) begin
            nxt_valid = 1'b1;
            nxt_data  = head.val[SAMPLE_W-1:0];
            void'(pending.pop_front());
          end
        end
        OP_CFG: begin
          if (energy_q.size() == 0) begin
            nxt_we    = 1'b1;
            nxt_idx   = head.idx;
            nxt_wdata = head.val;
            if (head.idx == CFG_ACTIVE_PEAKS)
              act_peaks = head.val[ACT_W-1:0];
            else if (head.idx <= NPEAKS)
              peak_cfg[head.idx - CFG_PEAK_BASE] = head.val;
            void'(pending.pop_front());
          end
        end
        OP_DRAIN: begin
          if (energy_q.size() == 0)
            void'(pending.pop_front());
        end
        default: void'(pending.pop_front());
      endcase
    end
    in_tvalid <= rst_n && nxt_valid;
    in_tdata  <= nxt_data;
    cfg_we    <= nxt_we;
    cfg_index <= nxt_idx;
    cfg_wdata <= nxt_wdata;
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin : observe
    energy_t want;
    logic    quiet;
    if (out_tvalid && out_tready) begin
      got++;
      if (energy_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: energy %0d sat %0b", $time,
                 $signed(out_tdata[ENERGY_W-1:0]), out_tuser);
      end else begin
        want = energy_q.pop_front();
        if (out_tdata[ENERGY_W-1:0] !== want.energy) begin
          errors++;
          $display("%0t: energy mismatch: expected %0d, actual %0d", $time,
                   want.energy, $signed(out_tdata[ENERGY_W-1:0]));
        end
        if (out_tuser !== want.sat) begin
          errors++;
          $display("%0t: saturated mismatch: expected %0b, actual %0b", $time,
                   want.sat, out_tuser);
        end
        if (out_tdata[OUT_TDATA_W-1:ENERGY_W] !== '0) begin
          errors++;
          $display("%0t: tdata padding mismatch: expected 0, actual %0h", $time,
                   out_tdata[OUT_TDATA_W-1:ENERGY_W]);
        end
      end
    end
    quiet = got >= QUIET_LO && got < QUIET_HI;
    out_tready <= quiet || $urandom_range(0, 99) >= 30;
  end

  // Watchdog: give up when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [95:0] t;
    // exp(-i/64) in Q1.16 by rounded repeated multiplication in Q0.32
    t = 96'd1 << 32;
    for (int i = 0; i < X_LIMIT; i++) begin
      exp_lut[i] = longint'((t + 96'd32768) >> 16);
      t = (t * 96'd4228380000 + (96'd1 << 31)) >> 32;
    end
    act_peaks = '0;
    for (int k = 0; k < NPEAKS; k++)
      peak_cfg[k] = '0;

    // One unit peak at zero: sample extremes and the edge of the exponent range
    put_cfg(CFG_IDX_W'(CFG_PEAK_BASE), {16'h0100, 16'h0000, 16'h0100});
    put_cfg(CFG_IDX_W'(CFG_ACTIVE_PEAKS), 48'hFFFF_FFFF_FFF9);
    put_sample(16'h0000);
    put_sample(16'h0001);
    put_sample(16'hFFFF);
    put_sample(16'h0100);
    put_sample(16'h0400);
    put_sample(16'h05A8);
    put_sample(16'h05A9);
    put_sample(16'hFA57);
    put_sample(16'h7FFF);
    put_sample(16'h8000);

    // Extreme peaks, a zero sigma, too many peaks and writes to unknown registers
    put_cfg(CFG_IDX_W'(CFG_PEAK_BASE + 0), {16'h7FFF, 16'h7FFF, 16'hFFFF});
    put_cfg(CFG_IDX_W'(CFG_PEAK_BASE + 1), {16'h8000, 16'h8000, 16'hFFFF});
    put_cfg(CFG_IDX_W'(CFG_PEAK_BASE + 2), {16'h7FFF, 16'h0000, 16'h0000});
    put_cfg(CFG_IDX_W'(CFG_PEAK_BASE + 3), {16'h8000, 16'h0100, 16'h0001});
    put_cfg(CFG_IDX_W'(CFG_ACTIVE_PEAKS), 48'hFFFF_FFFF_FFFF);
    for (int i = NPEAKS + 1; i < (1 << CFG_IDX_W); i++)
      put_cfg(CFG_IDX_W'(i), 48'hFFFF_FFFF_FFFF);
    put_sample(16'h7FFF);
    put_sample(16'h8000);
    put_sample(16'h0000);
    put_sample(16'h0100);
    put_sample(16'h0101);
    put_sample(16'h00FF);
    put_sample(16'h4000);
    put_sample(16'hC000);
    put_sample(16'hFFFF);
    put_sample(16'h0001);

    // No active peaks
    put_cfg(CFG_IDX_W'(CFG_ACTIVE_PEAKS), 48'h0);
    put_sample(16'h7FFF);
    put_sample(16'h0000);
    put_sample(16'h8000);

    for (int p = 0; p < 8; p++)
      add_random_phase(100);

    // Release reset, then wait for the queues to empty
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (pending.size() != 0 || in_tvalid || energy_q.size() != 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (energy_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, energy_q.size());
    end
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== gaussian_sum_potential.f =====
+incdir+hdl
hdl/gsp_pkg.sv
hdl/gsp_div_stage.sv
hdl/gsp_cell.sv
hdl/gaussian_sum_potential.sv
hdl/gsp_checker.sv
tb/testbench.sv
